// ===== rtl/jddm_pkg.sv =====
`default_nettype none
package jddm_pkg;

  // Fixed-point format of sticks and powers
  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int TWO_ONE   = 2 * ONE;
  localparam int R165      = (165 * ONE + 50) / 100;
  localparam int R15       = (3 * ONE) / 2;
  localparam int DIV_W     = 30;
  localparam int DEN_W     = 19;

  // Reciprocal of five: exact floor(n/5) for n below 2^22
  localparam int RECIP5    = 838861;
  localparam int RECIP5_SH = 22;

  // Configuration register indexes
  localparam logic [2:0] REG_DEAD_ZONE = 3'd0;
  localparam logic [2:0] REG_MAX_POWER = 3'd1;
  localparam logic [2:0] REG_IDLE_TO   = 3'd2;
  localparam logic [2:0] REG_BONUS_LF  = 3'd3;
  localparam logic [2:0] REG_BONUS_LR  = 3'd4;
  localparam logic [2:0] REG_BONUS_RF  = 3'd5;
  localparam logic [2:0] REG_BONUS_RR  = 3'd6;

  // Bridge direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  typedef struct packed {
    logic [14:0] dead_zone;
    logic [14:0] max_power;
    logic [15:0] idle_timeout_ms;
    logic [7:0]  bonus_left_forward;
    logic [7:0]  bonus_left_reverse;
    logic [7:0]  bonus_right_forward;
    logic [7:0]  bonus_right_reverse;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] target_turn;
    logic signed [15:0] target_throttle;
  } q_entry_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DEN_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_STEP, BS_STEP_WAIT, BS_EASE, BS_MUL1, BS_DIV1, BS_DIV1_WAIT,
    BS_MUL2, BS_MUL3, BS_SCALE, BS_RECIP, BS_SUM, BS_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/jddm_ifs.sv =====
`default_nettype none
interface jddm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic [31:0]        now_ms;
  modport source (output valid, stick_x, stick_y, now_ms, input ready);
  modport sink (input valid, stick_x, stick_y, now_ms, output ready);
endinterface

interface jddm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_power;
  logic signed [15:0] right_power;
  logic [1:0]         left_direction;
  logic [7:0]         left_duty;
  logic [1:0]         right_direction;
  logic [7:0]         right_duty;
  modport source (output valid, left_power, right_power, left_direction, left_duty,
                  right_direction, right_duty, input ready);
  modport sink (input valid, left_power, right_power, left_direction, left_duty,
                right_direction, right_duty, output ready);
endinterface
`default_nettype wire

// ===== rtl/jddm_div.sv =====
`default_nettype none
module jddm_div
  import jddm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire div_req_t req,
  output div_rsp_t  rsp
);

  logic             busy_r;
  logic             done_r;
  logic [4:0]       cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    diff    = trial - {1'b0, den_r};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        den_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_W-2:0], qbit};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/jddm_front.sv =====
`default_nettype none
module jddm_front
  import jddm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  jddm_in_if.sink    in_ch,
  input  wire logic  q_full,
  output logic       q_push,
  output q_entry_t   q_data
);

  logic signed [15:0] turn_r, throttle_r;
  logic [31:0]        last_r;
  logic signed [16:0] sx, sy, dz;
  logic               act_x, act_y, idle;
  logic [31:0]        last_nxt, elapsed;
  logic signed [15:0] turn_nxt, throttle_nxt;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Classify the sample against the dead zone and the idle timeout
  always_comb begin
    sx    = {in_ch.stick_x[15], in_ch.stick_x};
    sy    = {in_ch.stick_y[15], in_ch.stick_y};
    dz    = {2'b00, cfg.dead_zone};
    act_y = (sy > dz) || (sy < -dz);
    act_x = (sx > dz) || (sx < -dz);
    turn_nxt     = (act_y || act_x) ? in_ch.stick_x : turn_r;
    throttle_nxt = act_y ? in_ch.stick_y : throttle_r;
    last_nxt     = (act_y || act_x) ? in_ch.now_ms : last_r;
    elapsed      = in_ch.now_ms - last_nxt;
    idle         = elapsed > {16'd0, cfg.idle_timeout_ms};
    if (idle) begin
      turn_nxt     = '0;
      throttle_nxt = '0;
    end
    q_data.target_turn     = turn_nxt;
    q_data.target_throttle = throttle_nxt;
  end

  // Hold targets between beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r     <= '0;
      throttle_r <= '0;
      last_r     <= '0;
    end else if (q_push) begin
      turn_r     <= turn_nxt;
      throttle_r <= throttle_nxt;
      last_r     <= last_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jddm_queue.sv =====
`default_nettype none
module jddm_queue
  import jddm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output q_entry_t      pop_data
);

  q_entry_t   mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jddm_back.sv =====
`default_nettype none
module jddm_back
  import jddm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     q_not_empty,
  input  wire q_entry_t q_data,
  output logic          q_pop,
  jddm_out_if.source    out_ch
);

  back_state_t        state_r, state_nxt;
  logic signed [15:0] tt_r, tg_r, e_r;
  logic               wheel_r, xneg_r, psign_r;
  logic [29:0]        prod1_r;
  logic [16:0]        q1_r;
  logic signed [31:0] a_r;
  logic signed [48:0] p_r;
  logic [17:0]        n_r;
  logic [15:0]        t2_r;
  logic signed [15:0] lp_r, rp_r;
  logic               out_valid_r;
  logic               out_load;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic signed [16:0] x;
  logic signed [17:0] y18, om;
  logic signed [17:0] den18;
  logic signed [32:0] prod1_full;
  logic signed [33:0] a_full;
  logic signed [48:0] p_full, p_abs;
  logic [37:0]        n_prod;
  logic [16:0]        e_abs2;
  logic [18:0]        step_den;
  logic signed [16:0] delta, step;
  logic signed [15:0] e_nxt;
  logic signed [19:0] z, y20, q1s, t2s, one20, m20;
  logic [1:0]         ldir, rdir;
  logic [7:0]         lduty, rduty;

  jddm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Per-wheel operands
  always_comb begin
    x          = wheel_r ? {tt_r[15], tt_r} : -{tt_r[15], tt_r};
    y18        = {{2{e_r[15]}}, e_r};
    if (!e_r[15]) begin
      den18 = y18 + (wheel_r ? 18'(R165) : 18'(TWO_ONE));
      om    = 18'(ONE) - y18;
    end else begin
      den18 = (wheel_r ? 18'(R15) : 18'(TWO_ONE)) - y18;
      om    = 18'(ONE) + y18;
    end
    prod1_full = x * $signed({1'b0, cfg.max_power});
    a_full     = $signed({1'b0, cfg.max_power}) * om;
    p_full     = a_r * x;
    p_abs      = p_r[48] ? -p_r : p_r;
    n_prod     = {20'd0, n_r} * {18'd0, 20'(RECIP5)};
  end

  // Easing step
  always_comb begin
    e_abs2   = e_r[15] ? 17'(-{e_r[15], e_r}) : {1'b0, e_r};
    e_abs2   = e_abs2 << 1;
    step_den = 19'(ONE) + {2'b00, e_abs2};
    step_den = (step_den << 2) + step_den;
    step     = $signed({1'b0, drsp.quotient[15:0]});
    delta    = {tg_r[15], tg_r} - {e_r[15], e_r};
    if (delta > step)       e_nxt = 16'(e_r + step);
    else if (delta < -step) e_nxt = 16'(e_r - step);
    else                    e_nxt = tg_r;
  end

  // Combine terms and clamp
  always_comb begin
    one20 = 20'(ONE);
    m20   = {5'b0, cfg.max_power};
    y20   = {{4{e_r[15]}}, e_r};
    q1s   = {3'b0, q1_r};
    t2s   = psign_r ? -{4'b0, t2_r} : {4'b0, t2_r};
    if (xneg_r)       z = y20;
    else if (!e_r[15]) z = y20 - q1s + t2s;
    else              z = y20 + q1s - t2s;
    if (z > one20)  z = one20;
    if (z < -one20) z = -one20;
    if (z > m20)    z = m20;
    if (z < -m20)   z = -m20;
  end

  function automatic logic [9:0] drive(input logic signed [15:0] p, input logic [14:0] dzv,
                                       input logic [7:0] bf, input logic [7:0] br);
    logic signed [16:0] p17, dz17, mag;
    logic [22:0]        scaled;
    logic [9:0]         d;
    logic [1:0]         dir;
    p17  = {p[15], p};
    dz17 = {2'b00, dzv};
    mag  = '0;
    dir  = DIR_STOP;
    d    = '0;
    if (p17 > dz17) begin
      dir = DIR_FWD;
      mag = p17;
    end else if (p17 < -dz17) begin
      dir = DIR_REV;
      mag = -p17;
    end
    scaled = ({8'd0, mag[14:0]} << 8) - {8'd0, mag[14:0]};
    d = {1'b0, scaled[22:FRAC_BITS]} + ((dir == DIR_FWD) ? {2'b0, bf} : {2'b0, br});
    if (d > 10'd255) d = 10'd255;
    if (dir == DIR_STOP) d = '0;
    return {dir, d[7:0]};
  endfunction

  always_comb begin
    {ldir, lduty} = drive(lp_r, cfg.dead_zone, cfg.bonus_left_forward,
                          cfg.bonus_left_reverse);
    {rdir, rduty} = drive(rp_r, cfg.dead_zone, cfg.bonus_right_forward,
                          cfg.bonus_right_reverse);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE:      if (q_not_empty) state_nxt = BS_STEP;
      BS_STEP:      state_nxt = BS_STEP_WAIT;
      BS_STEP_WAIT: if (drsp.done) state_nxt = BS_EASE;
      BS_EASE:      state_nxt = BS_MUL1;
      BS_MUL1:      state_nxt = x[16] ? BS_SUM : BS_DIV1;
      BS_DIV1:      state_nxt = BS_DIV1_WAIT;
      BS_DIV1_WAIT: if (drsp.done) state_nxt = BS_MUL2;
      BS_MUL2:      state_nxt = BS_MUL3;
      BS_MUL3:      state_nxt = BS_SCALE;
      BS_SCALE:     state_nxt = BS_RECIP;
      BS_RECIP:     state_nxt = BS_SUM;
      BS_SUM:       state_nxt = wheel_r ? BS_OUT : BS_MUL1;
      BS_OUT:       if (out_load) state_nxt = BS_IDLE;
      default:      state_nxt = BS_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop         = (state_r == BS_IDLE) && q_not_empty;
    out_load      = (state_r == BS_OUT) && (!out_valid_r || out_ch.ready);
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    unique case (state_r)
      BS_STEP: begin
        dreq.start    = 1'b1;
        dreq.dividend = 30'(ONE * ONE);
        dreq.divisor  = step_den;
      end
      BS_DIV1: begin
        dreq.start    = 1'b1;
        dreq.dividend = prod1_r;
        dreq.divisor  = {1'b0, den18[17:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BS_IDLE;
    else        state_r <= state_nxt;
  end

  // Eased throttle
  always_ff @(posedge clk) begin
    if (!rst_n)                  e_r <= '0;
    else if (state_r == BS_EASE) e_r <= e_nxt;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      BS_IDLE: begin
        tt_r    <= q_data.target_turn;
        tg_r    <= q_data.target_throttle;
        wheel_r <= 1'b0;
      end
      BS_MUL1: begin
        xneg_r  <= x[16];
        prod1_r <= prod1_full[29:0];
      end
      BS_DIV1_WAIT: if (drsp.done) q1_r <= drsp.quotient[16:0];
      BS_MUL2: a_r <= a_full[31:0];
      BS_MUL3: p_r <= p_full;
      // Take 2|p| / 2^28, then divide by five through the reciprocal
      BS_SCALE: begin
        psign_r <= p_r[48];
        n_r     <= 18'(p_abs >>> (2 * FRAC_BITS - 1));
      end
      BS_RECIP: t2_r <= n_prod[RECIP5_SH+15:RECIP5_SH];
      BS_SUM: begin
        if (wheel_r) rp_r <= z[15:0];
        else         lp_r <= z[15:0];
        wheel_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r            <= 1'b1;
      out_ch.left_power      <= lp_r;
      out_ch.right_power     <= rp_r;
      out_ch.left_direction  <= ldir;
      out_ch.left_duty       <= lduty;
      out_ch.right_direction <= rdir;
      out_ch.right_duty      <= rduty;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/joystick_differential_drive_mixer.sv =====
`default_nettype none
// Joystick differential-drive mixer. Each input beat (stick_x turn, stick_y
// throttle in Q2.14, now_ms timestamp) yields one result beat with left and
// right wheel power, bridge direction and 8-bit duty. A front stage applies
// the dead zone and idle timeout at once and queues the targets (two deep);
// a back sequencer eases the throttle and mixes both wheels. The back runs
// its variable divisions through one shared 30-step radix-2 divider and
// divides by five with a reciprocal multiply. An item needs one division
// for the easing step plus one per wheel whose turn term is non-negative.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are taken any cycle
// and belong in idle periods.
module joystick_differential_drive_mixer
  import jddm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  jddm_in_if.sink          in_ch,
  jddm_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     q_full, q_push, q_pop, q_not_empty;
  q_entry_t q_in, q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone           <= 15'd1638;
      cfg_r.max_power           <= 15'(ONE);
      cfg_r.idle_timeout_ms     <= 16'd500;
      cfg_r.bonus_left_forward  <= '0;
      cfg_r.bonus_left_reverse  <= '0;
      cfg_r.bonus_right_forward <= '0;
      cfg_r.bonus_right_reverse <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEAD_ZONE: cfg_r.dead_zone           <= cfg_wdata[14:0];
        REG_MAX_POWER: cfg_r.max_power           <= cfg_wdata[14:0];
        REG_IDLE_TO:   cfg_r.idle_timeout_ms     <= cfg_wdata;
        REG_BONUS_LF:  cfg_r.bonus_left_forward  <= cfg_wdata[7:0];
        REG_BONUS_LR:  cfg_r.bonus_left_reverse  <= cfg_wdata[7:0];
        REG_BONUS_RF:  cfg_r.bonus_right_forward <= cfg_wdata[7:0];
        REG_BONUS_RR:  cfg_r.bonus_right_reverse <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  jddm_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_ch(in_ch),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  jddm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .pop_data(q_out)
  );

  jddm_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_not_empty(q_not_empty),
    .q_data(q_out), .q_pop(q_pop), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

// ===== bench/mixer_checker.sv =====
module mixer_checker
  import jddm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  jddm_in_if.sink   in_mon,
  jddm_out_if.sink  out_mon,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] lp;
    logic signed [15:0] rp;
    logic [1:0]         ldir;
    logic [7:0]         lduty;
    logic [1:0]         rdir;
    logic [7:0]         rduty;
  } wheels_t;

  wheels_t wheel_q[$];

  // Shadow registers and drive state
  longint dz, mp, idle_to, b_lf, b_lr, b_rf, b_rr;
  longint tgt_turn, tgt_thr, eased;
  logic [31:0] last_ms;

  function automatic longint clamp_power(longint z, longint m);
    if (z > ONE) z = ONE;
    if (z < -ONE) z = -ONE;
    if (z > m) z = m;
    if (z < -m) z = -m;
    return z;
  endfunction

  function automatic longint wheel_power(longint x, longint y, longint m, bit right);
    longint z, den;
    if (x < 0) z = y;
    else if (y >= 0) begin
      den = right ? y + R165 : y + 2 * ONE;
      z = y - (x * m) / den + (m * (ONE - y) * x * 2) / (5 * ONE * ONE);
    end else begin
      den = right ? R15 - y : 2 * ONE - y;
      z = y + (x * m) / den - (m * (ONE + y) * x * 2) / (5 * ONE * ONE);
    end
    return clamp_power(z, m);
  endfunction

  task automatic bridge(input longint p, input longint bf, input longint br,
                        output logic [1:0] dir, output logic [7:0] duty);
    longint d;
    if (p > dz) begin
      dir = DIR_FWD; d = (p * 255) / ONE + bf;
    end else if (p < -dz) begin
      dir = DIR_REV; d = (-p * 255) / ONE + br;
    end else begin
      dir = DIR_STOP; d = 0;
    end
    if (d > 255) d = 255;
    duty = d[7:0];
  endtask

  task automatic predict_tick(input longint sx, input longint sy, input logic [31:0] now);
    wheels_t w;
    longint stp, delta, lpw, rpw;
    logic [31:0] gap;
    if (sy > dz || sy < -dz) begin
      tgt_thr = sy; tgt_turn = sx; last_ms = now;
    end else if (sx > dz || sx < -dz) begin
      tgt_turn = sx; last_ms = now;
    end
    gap = now - last_ms;
    if (longint'(gap) > idle_to) begin
      tgt_turn = 0; tgt_thr = 0;
    end
    stp = (ONE * ONE) / (5 * (ONE + 2 * (eased < 0 ? -eased : eased)));
    delta = tgt_thr - eased;
    if (delta > stp) eased += stp;
    else if (delta < -stp) eased -= stp;
    else eased = tgt_thr;
    lpw = wheel_power(-tgt_turn, eased, mp, 1'b0);
    rpw = wheel_power(tgt_turn, eased, mp, 1'b1);
    w.lp = lpw[15:0];
    w.rp = rpw[15:0];
    bridge(lpw, b_lf, b_lr, w.ldir, w.lduty);
    bridge(rpw, b_rf, b_rr, w.rdir, w.rduty);
    wheel_q.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    wheels_t w;
    if (!rst_n) begin
      dz = 1638; mp = 16384; idle_to = 500;
      b_lf = 0; b_lr = 0; b_rf = 0; b_rr = 0;
      tgt_turn = 0; tgt_thr = 0; eased = 0; last_ms = 0;
      wheel_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_DEAD_ZONE: dz = cfg_wdata[14:0];
          REG_MAX_POWER: mp = cfg_wdata[14:0];
          REG_IDLE_TO:   idle_to = cfg_wdata;
          REG_BONUS_LF:  b_lf = cfg_wdata[7:0];
          REG_BONUS_LR:  b_lr = cfg_wdata[7:0];
          REG_BONUS_RF:  b_rf = cfg_wdata[7:0];
          REG_BONUS_RR:  b_rr = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // Compare result beat against oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (wheel_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          w = wheel_q.pop_front();
          if (out_mon.left_power !== w.lp)
            report_mismatch("left_power", out_mon.left_power, w.lp);
          if (out_mon.right_power !== w.rp)
            report_mismatch("right_power", out_mon.right_power, w.rp);
          if (out_mon.left_direction !== w.ldir)
            report_mismatch("left_direction", out_mon.left_direction, w.ldir);
          if (out_mon.left_duty !== w.lduty)
            report_mismatch("left_duty", out_mon.left_duty, w.lduty);
          if (out_mon.right_direction !== w.rdir)
            report_mismatch("right_direction", out_mon.right_direction, w.rdir);
          if (out_mon.right_duty !== w.rduty)
            report_mismatch("right_duty", out_mon.right_duty, w.rduty);
        end
      end
      // Predict each accepted tick
      if (in_mon.valid && in_mon.ready)
        predict_tick(in_mon.stick_x, in_mon.stick_y, in_mon.now_ms);
    end
    pending = wheel_q.size();
  end
endmodule

// ===== bench/testbench.sv =====
module testbench;
  import jddm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  int          fail_count, pending;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_off;
  logic [31:0] clock_ms;

  jddm_in_if  in_ch();
  jddm_out_if out_ch();

  joystick_differential_drive_mixer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mixer_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.stick_x = '0;
    in_ch.stick_y = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one beat and hold it until taken; drain or an idle gap drops valid
  task automatic send_tick(input logic [15:0] sx, input logic [15:0] sy,
                           input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.stick_x <= sx; in_ch.stick_y <= sy; in_ch.now_ms <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_stick();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom_range(3276) - 1638);
      3: return 16'($urandom());
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      clock_ms += ($urandom_range(9) == 0) ? $urandom() : $urandom_range(40);
      send_tick(pick_stick(), pick_stick(), clock_ms);
    end
  endtask

  initial begin
    send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0; clock_ms = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, turn only, dead zone edges, idle timeout, wrap
    send_tick(16'sd0, 16'sd16384, 32'd1);
    send_tick(16'sd16384, 16'sd16384, 32'd2);
    send_tick(-16'sd16384, 16'sd16384, 32'd3);
    send_tick(16'sd16384, -16'sd16384, 32'd4);
    send_tick(-16'sd16384, -16'sd16384, 32'd5);
    send_tick(16'sd12000, 16'sd0, 32'd6);
    send_tick(-16'sd12000, 16'sd1638, 32'd7);
    send_tick(16'sd1639, -16'sd1639, 32'd8);
    send_tick(16'sd1638, -16'sd1638, 32'd9);
    send_tick(16'sd0, 16'sd0, 32'd509);
    send_tick(16'sd0, 16'sd0, 32'd510);
    send_tick(16'sh7fff, 16'sh8000, 32'hffff_fff0);
    send_tick(16'sh8000, 16'sh7fff, 32'h0000_0010);
    send_tick(16'sd0, 16'sd0, 32'hffff_ffff);
    drain();

    // Extreme settings
    write_reg(REG_DEAD_ZONE, 16'h0000);
    write_reg(REG_MAX_POWER, 16'h7fff);
    write_reg(REG_IDLE_TO, 16'hffff);
    write_reg(REG_BONUS_LF, 16'h00ff);
    write_reg(REG_BONUS_LR, 16'h00ff);
    write_reg(REG_BONUS_RF, 16'h00ff);
    write_reg(REG_BONUS_RR, 16'h00ff);
    send_tick(16'sd1, -16'sd1, 32'd100);
    send_tick(16'sd16384, 16'sd8000, 32'd200);
    send_tick(-16'sd8000, -16'sd16384, 32'd300);
    drain();

    // Random, receiver idle heavy, then sender idle heavy
    send_idle_pct = 37; recv_idle_pct = 53;
    random_phase(200);
    drain();
    write_reg(REG_DEAD_ZONE, 16'd16384);
    write_reg(REG_MAX_POWER, 16'd0);
    write_reg(REG_IDLE_TO, 16'd0);
    write_reg(REG_BONUS_LF, 16'd0);
    write_reg(REG_BONUS_LR, 16'd0);
    write_reg(REG_BONUS_RF, 16'd0);
    write_reg(REG_BONUS_RR, 16'd0);
    send_idle_pct = 53; recv_idle_pct = 37;
    random_phase(100);
    drain();
    write_reg(REG_DEAD_ZONE, 16'($urandom_range(4000)));
    write_reg(REG_MAX_POWER, 16'($urandom_range(16384)));
    write_reg(REG_IDLE_TO, 16'($urandom_range(100)));
    write_reg(REG_BONUS_LF, 16'($urandom_range(255)));
    write_reg(REG_BONUS_LR, 16'($urandom_range(255)));
    write_reg(REG_BONUS_RF, 16'($urandom_range(255)));
    write_reg(REG_BONUS_RR, 16'($urandom_range(255)));
    random_phase(200);
    drain();

    // Long receiver hold-off so the block backs up
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_DEAD_ZONE, 16'd1638);
    write_reg(REG_MAX_POWER, 16'd16384);
    write_reg(REG_IDLE_TO, 16'd500);
    fork
      begin
        hold_off = 1;
        repeat (2000) @(negedge clk);
        hold_off = 0;
      end
      random_phase(20);
    join
    random_phase(380);
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
